/* hdl/key_value_table_assert.svh */
// Assertion macros for the table RTL.
`ifndef KEY_VALUE_TABLE_ASSERT_SVH
`define KEY_VALUE_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KVT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define KVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/kvt_pkg.sv */
`default_nettype none

package kvt_pkg;

    // Field widths on the stream ports
    localparam int CMD_W     = 3;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int CNT_W     = 5;

    // Request tdata layout, lowest bit first
    localparam int CMD_LSB   = 0;
    localparam int KEY_LSB   = CMD_LSB + CMD_W;
    localparam int VAL_LSB   = KEY_LSB + KEY_W;
    localparam int S_TDATA_W = 72;

    // Response tdata layout, lowest bit first
    localparam int ST_LSB    = 0;
    localparam int VOUT_LSB  = ST_LSB + STATUS_W;
    localparam int CNT_LSB   = VOUT_LSB + VAL_W;
    localparam int EMPTY_LSB = CNT_LSB + CNT_W;
    localparam int M_TDATA_W = 40;

    // Commands
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ACCESS = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic search;   // compare and load own response
        logic shift;    // fold in the neighbor's response
        logic wr_en;    // store the write key and value
        logic valid;    // entry lies below the count
        logic is_last;  // entry is the last valid one
    } t_cell_ctl;

endpackage

`default_nettype wire

/* hdl/kvt_cell.sv */
`default_nettype none

module kvt_cell #(
    parameter int KW       = 32,
    parameter int VW       = 32,
    parameter int IDX_BITS = 4,
    parameter int CELL_IDX = 0
) (
    input  wire                   i_clk,
    input  kvt_pkg::t_cell_ctl    i_ctl,
    input  wire  [KW-1:0]         i_key,
    input  wire  [KW-1:0]         i_wr_key,
    input  wire  [VW-1:0]         i_wr_value,
    input  wire                   i_nxt_hit,
    input  wire  [IDX_BITS-1:0]   i_nxt_idx,
    input  wire  [VW-1:0]         i_nxt_hval,
    input  wire  [KW-1:0]         i_nxt_lkey,
    input  wire  [VW-1:0]         i_nxt_lval,
    output logic                  o_hit,
    output logic [IDX_BITS-1:0]   o_idx,
    output logic [VW-1:0]         o_hval,
    output logic [KW-1:0]         o_lkey,
    output logic [VW-1:0]         o_lval
);

    logic [KW-1:0]       r_key;
    logic [VW-1:0]       r_val;
    logic                r_hit;
    logic [IDX_BITS-1:0] r_idx;
    logic [VW-1:0]       r_hval;
    logic [KW-1:0]       r_lkey;
    logic [VW-1:0]       r_lval;
    logic                w_own_hit;

    assign w_own_hit = i_ctl.valid && (r_key == i_key);

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_key <= i_wr_key;
            r_val <= i_wr_value;
        end
        // Responses are zero except in the hit cell and the last cell, so
        // OR-folding along the row leaves the answer in cell 0.
        if (i_ctl.search) begin
            r_hit  <= w_own_hit;
            r_idx  <= w_own_hit ? IDX_BITS'(CELL_IDX) : '0;
            r_hval <= w_own_hit ? r_val : '0;
            r_lkey <= i_ctl.is_last ? r_key : '0;
            r_lval <= i_ctl.is_last ? r_val : '0;
        end else if (i_ctl.shift) begin
            r_hit  <= r_hit | i_nxt_hit;
            r_idx  <= r_idx | i_nxt_idx;
            r_hval <= r_hval | i_nxt_hval;
            r_lkey <= r_lkey | i_nxt_lkey;
            r_lval <= r_lval | i_nxt_lval;
        end
    end

    assign o_hit  = r_hit;
    assign o_idx  = r_idx;
    assign o_hval = r_hval;
    assign o_lkey = r_lkey;
    assign o_lval = r_lval;

endmodule

`default_nettype wire

/* hdl/key_value_table.sv */
// Exact-match key/value table of ENTRIES entries held in a row of cells, one
// entry per cell. Requests (insert, access-or-create, get, erase, clear) are
// served one at a time and each gives exactly one response with status, value,
// entry count and empty flag. From acceptance a request passes through a
// search state in which every cell compares the key at once, a collect state
// in which the hit chain folds the cell responses one cell per cycle toward
// cell 0, and an apply state that applies the update and loads the response
// register once it is free or being read; the table then idles for the next
// request. A new key at a full table is refused with the full status. Keys
// and values keep their low KEY_BITS and VALUE_BITS bits (at most 32).
// entry_count is the count modulo 32. No clearing pass is needed after reset.
`default_nettype none

module key_value_table #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // command[2:0], key[34:3], value_in[66:35], zero pad [71:67]
    input  wire  [kvt_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    // status[1:0], value_out[33:2], entry_count[38:34], empty_res[39]
    output logic [kvt_pkg::M_TDATA_W-1:0]    o_m_axis_tdata
);

`include "key_value_table_assert.svh"

    localparam int KW       = (KEY_BITS < kvt_pkg::KEY_W) ? KEY_BITS : kvt_pkg::KEY_W;
    localparam int VW       = (VALUE_BITS < kvt_pkg::VAL_W) ? VALUE_BITS : kvt_pkg::VAL_W;
    localparam int IDX_BITS = $clog2(ENTRIES);
    localparam int CNT_BITS = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_COLLECT,
        S_APPLY
    } t_state;

    t_state                      r_state;
    logic [IDX_BITS-1:0]         r_shift;
    logic [CNT_BITS-1:0]         r_count;
    logic [kvt_pkg::CMD_W-1:0]   r_cmd;
    logic [KW-1:0]               r_key;
    logic [VW-1:0]               r_val;
    logic                        r_out_valid;
    logic [kvt_pkg::STATUS_W-1:0] r_out_status;
    logic [kvt_pkg::VAL_W-1:0]   r_out_value;
    logic [kvt_pkg::CNT_W-1:0]   r_out_count;
    logic                        r_out_empty;

    // Hit chain; the extra slot past the last cell feeds zeros
    logic                        w_hit  [ENTRIES+1];
    logic [IDX_BITS-1:0]         w_idx  [ENTRIES+1];
    logic [VW-1:0]               w_hval [ENTRIES+1];
    logic [KW-1:0]               w_lkey [ENTRIES+1];
    logic [VW-1:0]               w_lval [ENTRIES+1];

    logic                        w_accept;
    logic                        w_go;
    logic                        w_full;
    logic                        w_wr;
    logic [IDX_BITS-1:0]         w_wr_idx;
    logic [KW-1:0]               w_wr_key;
    logic [VW-1:0]               w_wr_val;
    logic [kvt_pkg::STATUS_W-1:0] w_status;
    logic [VW-1:0]               w_vout;
    logic [CNT_BITS-1:0]         n_count;
    logic [31:0]                 w_key_in;
    logic [31:0]                 w_val_in;
    logic [63:0]                 w_vout_ext;
    logic [31:0]                 w_cnt_ext;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_go            = (r_state == S_APPLY) && (!r_out_valid || i_m_axis_tready);
    assign w_full          = (r_count == CNT_BITS'(ENTRIES));

    assign w_key_in = i_s_axis_tdata[kvt_pkg::KEY_LSB +: kvt_pkg::KEY_W];
    assign w_val_in = i_s_axis_tdata[kvt_pkg::VAL_LSB +: kvt_pkg::VAL_W];

    assign w_hit[ENTRIES]  = 1'b0;
    assign w_idx[ENTRIES]  = '0;
    assign w_hval[ENTRIES] = '0;
    assign w_lkey[ENTRIES] = '0;
    assign w_lval[ENTRIES] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        kvt_pkg::t_cell_ctl w_ctl;

        assign w_ctl.search  = (r_state == S_SEARCH);
        assign w_ctl.shift   = (r_state == S_COLLECT);
        assign w_ctl.wr_en   = w_go && w_wr && (w_wr_idx == IDX_BITS'(g));
        assign w_ctl.valid   = (CNT_BITS'(g) < r_count);
        assign w_ctl.is_last = (CNT_BITS'(g + 1) == r_count);

        kvt_cell #(
            .KW       (KW),
            .VW       (VW),
            .IDX_BITS (IDX_BITS),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_key      (r_key),
            .i_wr_key   (w_wr_key),
            .i_wr_value (w_wr_val),
            .i_nxt_hit  (w_hit[g+1]),
            .i_nxt_idx  (w_idx[g+1]),
            .i_nxt_hval (w_hval[g+1]),
            .i_nxt_lkey (w_lkey[g+1]),
            .i_nxt_lval (w_lval[g+1]),
            .o_hit      (w_hit[g]),
            .o_idx      (w_idx[g]),
            .o_hval     (w_hval[g]),
            .o_lkey     (w_lkey[g]),
            .o_lval     (w_lval[g])
        );
    end

    // Outcome of the request, from the folded response in cell 0
    always_comb begin
        w_wr     = 1'b0;
        w_wr_idx = r_count[IDX_BITS-1:0];
        w_wr_key = r_key;
        w_wr_val = r_val;
        w_status = kvt_pkg::ST_OK;
        w_vout   = '0;
        n_count  = r_count;
        unique case (r_cmd)
            kvt_pkg::CMD_INSERT, kvt_pkg::CMD_ACCESS: begin
                if (w_hit[0]) begin
                    if (r_cmd == kvt_pkg::CMD_INSERT) begin
                        w_wr     = 1'b1;
                        w_wr_idx = w_idx[0];
                    end else begin
                        w_vout = w_hval[0];
                    end
                end else if (w_full) begin
                    w_status = kvt_pkg::ST_FULL;
                end else begin
                    w_wr    = 1'b1;
                    n_count = r_count + CNT_BITS'(1);
                    if (r_cmd == kvt_pkg::CMD_ACCESS) begin
                        w_wr_val = '0;
                    end
                end
            end
            kvt_pkg::CMD_GET: begin
                if (w_hit[0]) begin
                    w_vout = w_hval[0];
                end else begin
                    w_status = kvt_pkg::ST_ABSENT;
                end
            end
            kvt_pkg::CMD_ERASE: begin
                // last entry moves into the freed slot
                if (w_hit[0]) begin
                    w_wr     = 1'b1;
                    w_wr_idx = w_idx[0];
                    w_wr_key = w_lkey[0];
                    w_wr_val = w_lval[0];
                    n_count  = r_count - CNT_BITS'(1);
                end else begin
                    w_status = kvt_pkg::ST_ABSENT;
                end
            end
            kvt_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    assign w_vout_ext = 64'(w_vout);
    assign w_cnt_ext  = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_shift     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new response may load while the old one leaves
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd   <= i_s_axis_tdata[kvt_pkg::CMD_LSB +: kvt_pkg::CMD_W];
                        r_key   <= w_key_in[KW-1:0];
                        r_val   <= w_val_in[VW-1:0];
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    r_shift <= '0;
                    r_state <= S_COLLECT;
                end
                S_COLLECT: begin
                    r_shift <= r_shift + IDX_BITS'(1);
                    if (r_shift == IDX_BITS'(ENTRIES - 2)) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (w_go) begin
                        r_count      <= n_count;
                        r_out_status <= w_status;
                        r_out_value  <= w_vout_ext[kvt_pkg::VAL_W-1:0];
                        r_out_count  <= w_cnt_ext[kvt_pkg::CNT_W-1:0];
                        r_out_empty  <= (n_count == '0);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_empty, r_out_count, r_out_value, r_out_status};

    `KVT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_BITS'(ENTRIES), "entry count above capacity")
    `KVT_ASSERT_NEXT(a_accept_search, i_clk, i_rst_n, w_accept,
        r_state == S_SEARCH, "accepted transaction did not start a search")
    `KVT_ASSERT_NOW(a_hit_needs_entry, i_clk, i_rst_n, (r_state == S_APPLY) && w_hit[0],
        r_count != '0, "hit reported in an empty table")
    `KVT_ASSERT_NEXT(a_erase_count, i_clk, i_rst_n,
        w_go && (r_cmd == kvt_pkg::CMD_ERASE) && w_hit[0],
        r_count == $past(r_count) - CNT_BITS'(1), "erase did not drop the count")
    `KVT_ASSERT_NOW(a_empty_flag, i_clk, i_rst_n, r_out_valid && (r_out_count != '0),
        !r_out_empty, "empty flag set with entries present")

endmodule

`default_nettype wire
